// ===== rtl/btff_pkg.sv =====
// shared types, codes and tag helpers for the boundary tag first-fit allocator
// no dependencies; used by every module of the block
package btff_pkg;

   localparam int HEAP_BYTES_DEFAULT = 65536;
   localparam int TAG_W  = 17;
   localparam int ADDR_W = 32;
   localparam int NEED_W = 18;

   typedef logic [TAG_W-1:0]  tag_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [NEED_W-1:0] need_type;

   // item kinds
   localparam logic [1:0] KIND_FORMAT = 2'd0;
   localparam logic [1:0] KIND_ALLOC  = 2'd1;
   localparam logic [1:0] KIND_FREE   = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_NOFIT   = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;
   localparam logic [1:0] STATUS_NOTFMT  = 2'd3;

   localparam tag_type  HEAP_LEN_RESET = 17'h10000;
   localparam tag_type  MIN_HEAP       = 17'd32;
   localparam tag_type  SPLIT_MIN      = 17'd16;
   localparam addr_type FIRST_HDR      = 32'd8;
   localparam addr_type WORD_BYTES     = 32'd8;
   localparam addr_type HDR_PAD        = 32'd23;
   localparam addr_type SIZE_GUARD     = 32'd16;

   typedef struct packed {
      logic [1:0]  kind;
      logic [16:0] request_bytes;
      logic [15:0] release_offset;
   } req_type;

   typedef struct packed {
      logic [15:0] granted_offset;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      addr_type a;
      addr_type b;
      logic     sub;
   } alu_op_type;

   typedef struct packed {
      addr_type sum;
      logic     borrow;
   } alu_res_type;

   typedef struct packed {
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      tag_type  wr_data;
   } mem_req_type;

   function automatic addr_type ext_tag(input tag_type t);
      return {{(ADDR_W-TAG_W){1'b0}}, t};
   endfunction

   function automatic tag_type size_of(input tag_type t);
      return {t[TAG_W-1:4], 4'b0000};
   endfunction

   function automatic tag_type tag_word(input tag_type size, input logic alloc,
                                        input logic prev);
      return {size[TAG_W-1:4], 2'b00, prev, alloc};
   endfunction

endpackage

// ===== rtl/btff_alu.sv =====
// shared 32-bit add/subtract unit used by the allocator sequencer
// depends on btff_pkg for the operand and result structs
module btff_alu (
   input  btff_pkg::alu_op_type  alu_op,
   output btff_pkg::alu_res_type alu_res
);

   logic [btff_pkg::ADDR_W-1:0] b_sel;
   logic [btff_pkg::ADDR_W:0]   full;

   // subtract as a + ~b + 1, borrow is the missing carry
   assign b_sel = alu_op.sub ? ~alu_op.b : alu_op.b;
   assign full  = {1'b0, alu_op.a} + {1'b0, b_sel}
                  + {{btff_pkg::ADDR_W{1'b0}}, alu_op.sub};

   assign alu_res.sum    = full[btff_pkg::ADDR_W-1:0];
   assign alu_res.borrow = alu_op.sub & ~full[btff_pkg::ADDR_W];

endmodule

// ===== rtl/btff_heap_mem.sv =====
// heap tag memory: one write port, one registered read port, byte addressed
// words beyond the heap read as zero and writes there are dropped; uses btff_pkg
module btff_heap_mem #(
   parameter int HEAP_BYTES = btff_pkg::HEAP_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  btff_pkg::mem_req_type mem_req,
   output btff_pkg::tag_type     rd_data
);

   localparam int WORD_COUNT = HEAP_BYTES / 8;
   localparam int AW         = $clog2(WORD_COUNT);
   localparam int IDX_W      = btff_pkg::ADDR_W - 3;

   btff_pkg::tag_type heap_mem_ff [WORD_COUNT];
   btff_pkg::tag_type rd_q_ff;
   logic              rd_ok_ff;
   logic              rd_ok_in;
   logic              wr_ok;
   logic [AW-1:0]     rd_idx;
   logic [AW-1:0]     wr_idx;

   assign rd_ok_in = mem_req.rd_addr[btff_pkg::ADDR_W-1:3] < IDX_W'(WORD_COUNT);
   assign wr_ok    = mem_req.wr_addr[btff_pkg::ADDR_W-1:3] < IDX_W'(WORD_COUNT);
   assign rd_idx   = mem_req.rd_addr[AW+2:3];
   assign wr_idx   = mem_req.wr_addr[AW+2:3];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en && wr_ok) begin
         heap_mem_ff[wr_idx] <= mem_req.wr_data;
      end
      rd_q_ff  <= heap_mem_ff[rd_idx];
      rd_ok_ff <= rd_ok_in;
   end

   assign rd_data = rd_ok_ff ? rd_q_ff : '0;

endmodule

// ===== rtl/btff_seq.sv =====
// sequencer of the allocator: walks block tags through the heap memory,
// one read or write per step, all address and size math on the shared alu; uses btff_pkg
module btff_seq #(
   parameter int HEAP_BYTES = btff_pkg::HEAP_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  btff_pkg::req_type     req_item,
   input  btff_pkg::tag_type     heap_length,
   output btff_pkg::alu_op_type  alu_op,
   input  btff_pkg::alu_res_type alu_res,
   output btff_pkg::mem_req_type mem_req,
   input  btff_pkg::tag_type     mem_rd_data,
   output logic                  rsp_strobe,
   output btff_pkg::rsp_type     rsp_item
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_RESP    = 5'd1;
   localparam logic [4:0] S_FMT_HDR = 5'd2;
   localparam logic [4:0] S_FMT_FTR = 5'd3;
   localparam logic [4:0] S_FMT_END = 5'd4;
   localparam logic [4:0] S_AL_NEED = 5'd5;
   localparam logic [4:0] S_AL_RD   = 5'd6;
   localparam logic [4:0] S_AL_CHK  = 5'd7;
   localparam logic [4:0] S_AL_NEXT = 5'd8;
   localparam logic [4:0] S_AL_SPL1 = 5'd9;
   localparam logic [4:0] S_AL_SPL2 = 5'd10;
   localparam logic [4:0] S_AL_SPL3 = 5'd11;
   localparam logic [4:0] S_AL_WH1  = 5'd12;
   localparam logic [4:0] S_AL_WH2  = 5'd13;
   localparam logic [4:0] S_AL_WH3  = 5'd14;
   localparam logic [4:0] S_AL_GRNT = 5'd15;
   localparam logic [4:0] S_FR_H    = 5'd16;
   localparam logic [4:0] S_FR_RD1  = 5'd17;
   localparam logic [4:0] S_FR_WR1  = 5'd18;
   localparam logic [4:0] S_FR_FTR  = 5'd19;
   localparam logic [4:0] S_FR_RD2  = 5'd20;
   localparam logic [4:0] S_FR_WR2  = 5'd21;
   localparam logic [4:0] S_FR_RD3  = 5'd22;
   localparam logic [4:0] S_FR_RD4  = 5'd23;
   localparam logic [4:0] S_FR_BR   = 5'd24;
   localparam logic [4:0] S_FR_PRD  = 5'd25;
   localparam logic [4:0] S_FR_PS   = 5'd26;
   localparam logic [4:0] S_FR_SUM1 = 5'd27;
   localparam logic [4:0] S_FR_SUM2 = 5'd28;
   localparam logic [4:0] S_MG_RD   = 5'd29;
   localparam logic [4:0] S_MG_WR   = 5'd30;
   localparam logic [4:0] S_MG_FTR  = 5'd31;

   localparam btff_pkg::addr_type HEAP_LIM = 32'(HEAP_BYTES);

   logic [4:0]         state_ff, state_in;
   logic               formatted_ff, formatted_in;
   btff_pkg::req_type  req_ff, req_in;
   btff_pkg::need_type need_ff, need_in;
   btff_pkg::addr_type blk_ff, blk_in;
   btff_pkg::addr_type tmp_ff, tmp_in;
   btff_pkg::addr_type h_ff, h_in;
   btff_pkg::addr_type nx_ff, nx_in;
   btff_pkg::addr_type mb_ff, mb_in;
   btff_pkg::tag_type  bsize_ff, bsize_in;
   btff_pkg::tag_type  rem_ff, rem_in;
   btff_pkg::tag_type  s_ff, s_in;
   btff_pkg::tag_type  ps_ff, ps_in;
   btff_pkg::tag_type  tot_ff, tot_in;
   logic               prev_ff, prev_in;
   logic               p_ff, p_in;
   logic [15:0]        granted_ff, granted_in;
   logic [1:0]         status_ff, status_in;

   btff_pkg::tag_type  len_clamp;
   btff_pkg::tag_type  len_fmt;
   btff_pkg::tag_type  rd_size;

   // heap length used by a format item
   always_comb begin
      len_clamp = (btff_pkg::ext_tag(heap_length) > HEAP_LIM) ?
                  HEAP_LIM[btff_pkg::TAG_W-1:0] : heap_length;
      len_fmt   = btff_pkg::size_of(len_clamp);
      if (len_fmt < btff_pkg::MIN_HEAP) begin
         len_fmt = btff_pkg::MIN_HEAP;
      end
   end

   assign rd_size = btff_pkg::size_of(mem_rd_data);

   always_comb begin
      state_in     = state_ff;
      formatted_in = formatted_ff;
      req_in       = req_ff;
      need_in      = need_ff;
      blk_in       = blk_ff;
      tmp_in       = tmp_ff;
      h_in         = h_ff;
      nx_in        = nx_ff;
      mb_in        = mb_ff;
      bsize_in     = bsize_ff;
      rem_in       = rem_ff;
      s_in         = s_ff;
      ps_in        = ps_ff;
      tot_in       = tot_ff;
      prev_in      = prev_ff;
      p_in         = p_ff;
      granted_in   = granted_ff;
      status_in    = status_ff;
      alu_op       = '0;
      mem_req      = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in     = req_item;
               granted_in = '0;
               status_in  = btff_pkg::STATUS_DONE;
               state_in   = S_RESP;
               case (req_item.kind)
                  btff_pkg::KIND_FORMAT: begin
                     state_in = S_FMT_HDR;
                  end
                  btff_pkg::KIND_ALLOC: begin
                     if (!formatted_ff) begin
                        status_in = btff_pkg::STATUS_NOTFMT;
                     end else if (req_item.request_bytes == '0) begin
                        status_in = btff_pkg::STATUS_IGNORED;
                     end else begin
                        state_in = S_AL_NEED;
                     end
                  end
                  btff_pkg::KIND_FREE: begin
                     if (!formatted_ff) begin
                        status_in = btff_pkg::STATUS_NOTFMT;
                     end else if (req_item.release_offset[15:3] == '0) begin
                        status_in = btff_pkg::STATUS_IGNORED;
                     end else begin
                        state_in = S_FR_H;
                     end
                  end
                  default: begin
                     status_in = btff_pkg::STATUS_IGNORED;
                  end
               endcase
            end
         end
         S_FMT_HDR: begin
            alu_op          = '{a: btff_pkg::ext_tag(len_fmt), b: btff_pkg::SIZE_GUARD,
                                sub: 1'b1};
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = btff_pkg::FIRST_HDR;
            mem_req.wr_data = btff_pkg::tag_word(alu_res.sum[btff_pkg::TAG_W-1:0], 1'b0,
                                                 1'b1);
            state_in        = S_FMT_FTR;
         end
         S_FMT_FTR: begin
            alu_op          = '{a: btff_pkg::ext_tag(len_fmt), b: btff_pkg::SIZE_GUARD,
                                sub: 1'b1};
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = alu_res.sum;
            mem_req.wr_data = alu_res.sum[btff_pkg::TAG_W-1:0];
            state_in        = S_FMT_END;
         end
         S_FMT_END: begin
            // zero-size end marker, allocated, prev allocated
            alu_op          = '{a: btff_pkg::ext_tag(len_fmt), b: btff_pkg::WORD_BYTES,
                                sub: 1'b1};
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = alu_res.sum;
            mem_req.wr_data = btff_pkg::tag_word('0, 1'b1, 1'b1);
            formatted_in    = 1'b1;
            state_in        = S_RESP;
         end
         S_AL_NEED: begin
            alu_op   = '{a: {15'd0, req_ff.request_bytes}, b: btff_pkg::HDR_PAD, sub: 1'b0};
            need_in  = {alu_res.sum[btff_pkg::NEED_W-1:4], 4'b0000};
            blk_in   = btff_pkg::FIRST_HDR;
            state_in = S_AL_RD;
         end
         S_AL_RD: begin
            mem_req.rd_addr = blk_ff;
            state_in        = S_AL_CHK;
         end
         S_AL_CHK: begin
            alu_op   = '{a: btff_pkg::ext_tag(rd_size), b: {14'd0, need_ff}, sub: 1'b1};
            bsize_in = rd_size;
            prev_in  = mem_rd_data[1];
            rem_in   = alu_res.sum[btff_pkg::TAG_W-1:0];
            if (rd_size == '0) begin
               status_in = btff_pkg::STATUS_NOFIT;
               state_in  = S_RESP;
            end else if (!mem_rd_data[0] && !alu_res.borrow) begin
               // split only when the remainder is bigger than a minimum block
               if (alu_res.sum[btff_pkg::TAG_W-1:0] > btff_pkg::SPLIT_MIN) begin
                  state_in = S_AL_SPL1;
               end else begin
                  state_in = S_AL_WH1;
               end
            end else begin
               state_in = S_AL_NEXT;
            end
         end
         S_AL_NEXT: begin
            alu_op   = '{a: blk_ff, b: btff_pkg::ext_tag(bsize_ff), sub: 1'b0};
            blk_in   = alu_res.sum;
            state_in = S_AL_RD;
         end
         S_AL_SPL1: begin
            alu_op          = '{a: blk_ff, b: btff_pkg::ext_tag(bsize_ff), sub: 1'b0};
            tmp_in          = alu_res.sum;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = blk_ff;
            mem_req.wr_data = btff_pkg::tag_word(need_ff[btff_pkg::TAG_W-1:0], 1'b1,
                                                 prev_ff);
            state_in        = S_AL_SPL2;
         end
         S_AL_SPL2: begin
            alu_op          = '{a: blk_ff, b: {14'd0, need_ff}, sub: 1'b0};
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = alu_res.sum;
            mem_req.wr_data = btff_pkg::tag_word(rem_ff, 1'b0, 1'b1);
            state_in        = S_AL_SPL3;
         end
         S_AL_SPL3: begin
            // footer of the remainder
            alu_op          = '{a: tmp_ff, b: btff_pkg::WORD_BYTES, sub: 1'b1};
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = alu_res.sum;
            mem_req.wr_data = rem_ff;
            state_in        = S_AL_GRNT;
         end
         S_AL_WH1: begin
            alu_op          = '{a: blk_ff, b: btff_pkg::ext_tag(bsize_ff), sub: 1'b0};
            tmp_in          = alu_res.sum;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = blk_ff;
            mem_req.wr_data = btff_pkg::tag_word(bsize_ff, 1'b1, prev_ff);
            state_in        = S_AL_WH2;
         end
         S_AL_WH2: begin
            mem_req.rd_addr = tmp_ff;
            state_in        = S_AL_WH3;
         end
         S_AL_WH3: begin
            // next block now has an allocated neighbor in front
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = tmp_ff;
            mem_req.wr_data = btff_pkg::tag_word(mem_rd_data, mem_rd_data[0], 1'b1);
            state_in        = S_AL_GRNT;
         end
         S_AL_GRNT: begin
            alu_op     = '{a: blk_ff, b: btff_pkg::WORD_BYTES, sub: 1'b0};
            granted_in = alu_res.sum[15:0];
            state_in   = S_RESP;
         end
         S_FR_H: begin
            alu_op   = '{a: {16'd0, req_ff.release_offset[15:3], 3'b000},
                         b: btff_pkg::WORD_BYTES, sub: 1'b1};
            h_in     = alu_res.sum;
            state_in = S_FR_RD1;
         end
         S_FR_RD1: begin
            mem_req.rd_addr = h_ff;
            state_in        = S_FR_WR1;
         end
         S_FR_WR1: begin
            alu_op          = '{a: h_ff, b: btff_pkg::ext_tag(rd_size), sub: 1'b0};
            nx_in           = alu_res.sum;
            s_in            = rd_size;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = h_ff;
            mem_req.wr_data = btff_pkg::tag_word(mem_rd_data, 1'b0, mem_rd_data[1]);
            state_in        = S_FR_FTR;
         end
         S_FR_FTR: begin
            alu_op          = '{a: nx_ff, b: btff_pkg::WORD_BYTES, sub: 1'b1};
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = alu_res.sum;
            mem_req.wr_data = s_ff;
            state_in        = S_FR_RD2;
         end
         S_FR_RD2: begin
            mem_req.rd_addr = nx_ff;
            state_in        = S_FR_WR2;
         end
         S_FR_WR2: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = nx_ff;
            mem_req.wr_data = btff_pkg::tag_word(mem_rd_data, mem_rd_data[0], 1'b0);
            state_in        = S_FR_RD3;
         end
         S_FR_RD3: begin
            // fresh reads: the writes above may have landed on these tags
            mem_req.rd_addr = h_ff;
            state_in        = S_FR_RD4;
         end
         S_FR_RD4: begin
            p_in            = mem_rd_data[1];
            mem_req.rd_addr = nx_ff;
            state_in        = S_FR_BR;
         end
         S_FR_BR: begin
            if (!p_ff) begin
               tot_in   = mem_rd_data[0] ? '0 : rd_size;
               state_in = S_FR_PRD;
            end else if (!mem_rd_data[0]) begin
               alu_op   = '{a: btff_pkg::ext_tag(rd_size), b: btff_pkg::ext_tag(s_ff),
                            sub: 1'b0};
               tot_in   = alu_res.sum[btff_pkg::TAG_W-1:0];
               mb_in    = h_ff;
               state_in = S_MG_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_FR_PRD: begin
            // footer of the block in front
            alu_op          = '{a: h_ff, b: btff_pkg::WORD_BYTES, sub: 1'b1};
            mem_req.rd_addr = alu_res.sum;
            state_in        = S_FR_PS;
         end
         S_FR_PS: begin
            alu_op   = '{a: h_ff, b: btff_pkg::ext_tag(rd_size), sub: 1'b1};
            ps_in    = rd_size;
            mb_in    = alu_res.sum;
            state_in = S_FR_SUM1;
         end
         S_FR_SUM1: begin
            alu_op   = '{a: btff_pkg::ext_tag(ps_ff), b: btff_pkg::ext_tag(tot_ff),
                         sub: 1'b0};
            tot_in   = alu_res.sum[btff_pkg::TAG_W-1:0];
            state_in = S_FR_SUM2;
         end
         S_FR_SUM2: begin
            alu_op   = '{a: btff_pkg::ext_tag(tot_ff), b: btff_pkg::ext_tag(s_ff),
                         sub: 1'b0};
            tot_in   = alu_res.sum[btff_pkg::TAG_W-1:0];
            state_in = S_MG_RD;
         end
         S_MG_RD: begin
            mem_req.rd_addr = mb_ff;
            state_in        = S_MG_WR;
         end
         S_MG_WR: begin
            alu_op          = '{a: mb_ff, b: btff_pkg::ext_tag(btff_pkg::size_of(tot_ff)),
                                sub: 1'b0};
            tmp_in          = alu_res.sum;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = mb_ff;
            mem_req.wr_data = btff_pkg::tag_word(tot_ff, 1'b0, mem_rd_data[1]);
            state_in        = S_MG_FTR;
         end
         S_MG_FTR: begin
            alu_op          = '{a: tmp_ff, b: btff_pkg::WORD_BYTES, sub: 1'b1};
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = alu_res.sum;
            mem_req.wr_data = tot_ff;
            state_in        = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         formatted_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         formatted_ff <= formatted_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      need_ff    <= need_in;
      blk_ff     <= blk_in;
      tmp_ff     <= tmp_in;
      h_ff       <= h_in;
      nx_ff      <= nx_in;
      mb_ff      <= mb_in;
      bsize_ff   <= bsize_in;
      rem_ff     <= rem_in;
      s_ff       <= s_in;
      ps_ff      <= ps_in;
      tot_ff     <= tot_in;
      prev_ff    <= prev_in;
      p_ff       <= p_in;
      granted_ff <= granted_in;
      status_ff  <= status_in;
   end

   assign busy                    = (state_ff != S_IDLE);
   assign rsp_strobe              = (state_ff == S_RESP);
   assign rsp_item.granted_offset = granted_ff;
   assign rsp_item.status         = status_ff;

endmodule

// ===== rtl/boundary_tag_first_fit_allocator.sv =====
// throughput: one item at a time; a new start is taken the cycle after the strobe,
// set by the single heap memory port and the one shared adder
// reset: synchronous; clears the sequencer and the formatted flag, heap length to 65536,
// heap memory holds garbage until a format item; results cannot be stalled
module boundary_tag_first_fit_allocator #(
   parameter int HEAP_BYTES = btff_pkg::HEAP_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  btff_pkg::req_type req_item,
   output logic              rsp_strobe,
   output btff_pkg::rsp_type rsp_item,
   input  logic              csr_we,
   input  btff_pkg::tag_type csr_wdata
);

   btff_pkg::tag_type     heap_length_ff;
   btff_pkg::tag_type     heap_length_in;
   btff_pkg::alu_op_type  alu_op;
   btff_pkg::alu_res_type alu_res;
   btff_pkg::mem_req_type mem_req;
   btff_pkg::tag_type     mem_rd_data;

   assign heap_length_in = csr_we ? csr_wdata : heap_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_length_ff <= btff_pkg::HEAP_LEN_RESET;
      end else begin
         heap_length_ff <= heap_length_in;
      end
   end

   btff_alu u_alu (
      .alu_op  (alu_op),
      .alu_res (alu_res)
   );

   btff_heap_mem #(
      .HEAP_BYTES (HEAP_BYTES)
   ) u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   btff_seq #(
      .HEAP_BYTES (HEAP_BYTES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .heap_length (heap_length_ff),
      .alu_op      (alu_op),
      .alu_res     (alu_res),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("result strobe longer than one cycle or block stayed busy");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != btff_pkg::STATUS_DONE)
      |-> (rsp_item.granted_offset == '0))
      else $error("nonzero offset on a failed item");
`endif

endmodule

// ===== tb/sv/tb_boundary_tag_first_fit_allocator.sv =====
// testbench for the boundary tag first-fit allocator: directed and random items,
// every result checked against a heap predictor kept inside the bench
// depends on btff_pkg and boundary_tag_first_fit_allocator
module tb_boundary_tag_first_fit_allocator;
   import btff_pkg::*;

   localparam logic [1:0]  KIND_UNKNOWN = 2'd3;
   localparam int unsigned HEAP_WORDS   = HEAP_BYTES_DEFAULT / 8;
   localparam addr_type    SIZE_FIELD   = 32'h1FFF0;
   localparam addr_type    TAG_FIELD    = 32'h1FFFF;
   localparam int unsigned STALL_LIMIT  = 100000;
   localparam int unsigned TAIL_CYCLES  = 40;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;
   logic    csr_we;
   tag_type csr_wdata;

   // predicted heap image and what has been written since reset
   tag_type     heap_model    [HEAP_WORDS];
   bit          heap_written  [HEAP_WORDS];
   tag_type     heap_saved    [HEAP_WORDS];
   bit          written_saved [HEAP_WORDS];
   bit          model_formatted;
   bit          formatted_saved;
   bit          blank_read;
   tag_type     model_heap_len;

   rsp_type     expected_rsps [$];
   logic [15:0] live_offsets [$];
   logic [15:0] last_grant;
   int unsigned sender_idle_pct;
   int unsigned mismatches;
   int unsigned stalled_cycles;
   bit          start_high;

   boundary_tag_first_fit_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------- heap predictor ----------------

   function automatic addr_type fetch_tag(input addr_type a);
      addr_type idx;
      idx = a >> 3;
      if (idx >= HEAP_WORDS) return '0;
      if (!heap_written[idx]) blank_read = 1'b1;
      return {15'b0, heap_model[idx]};
   endfunction

   function automatic void store_tag(input addr_type a, input addr_type v);
      addr_type idx;
      idx = a >> 3;
      if (idx < HEAP_WORDS) begin
         heap_model[idx]   = v[TAG_W-1:0];
         heap_written[idx] = 1'b1;
      end
   endfunction

   function automatic addr_type tag_size_at(input addr_type a);
      return fetch_tag(a) & SIZE_FIELD;
   endfunction

   function automatic logic is_alloc(input addr_type a);
      addr_type t;
      t = fetch_tag(a);
      return t[0];
   endfunction

   function automatic logic prev_alloc(input addr_type a);
      addr_type t;
      t = fetch_tag(a);
      return t[1];
   endfunction

   function automatic void set_tag(input addr_type a, input addr_type size,
                                   input logic alloc, input logic prev);
      store_tag(a, size | {30'b0, prev, alloc});
   endfunction

   function automatic void format_heap();
      addr_type len;
      len = {15'b0, model_heap_len};
      if (len > HEAP_BYTES_DEFAULT) len = HEAP_BYTES_DEFAULT;
      len = len & ~32'hF;
      if (len < 32) len = 32;
      set_tag(FIRST_HDR, len - 16, 1'b0, 1'b1);
      store_tag(len - 16, len - 16);
      set_tag(len - WORD_BYTES, '0, 1'b1, 1'b1);
      model_formatted = 1'b1;
   endfunction

   function automatic logic [1:0] grant_block(input logic [16:0] bytes,
                                              output logic [15:0] offset);
      addr_type need, blk, bsize, rem, nx;
      offset = '0;
      need = ({15'b0, bytes} + HDR_PAD) & ~32'hF;
      blk = FIRST_HDR;
      bsize = tag_size_at(blk);
      // first fit: walk headers until a free block is big enough or the end tag
      while (bsize != 0 && (is_alloc(blk) || bsize < need)) begin
         blk = blk + bsize;
         bsize = tag_size_at(blk);
      end
      if (bsize == 0) return STATUS_NOFIT;
      if (bsize - need > SIZE_GUARD) begin
         rem = bsize - need;
         set_tag(blk, need, 1'b1, prev_alloc(blk));
         set_tag(blk + need, rem, 1'b0, 1'b1);
         store_tag(blk + bsize - WORD_BYTES, rem);
      end else begin
         nx = blk + bsize;
         set_tag(blk, bsize, 1'b1, prev_alloc(blk));
         set_tag(nx, tag_size_at(nx), is_alloc(nx), 1'b1);
      end
      offset = blk[15:0] + 16'd8;
      return STATUS_DONE;
   endfunction

   function automatic void release_block(input logic [15:0] off);
      addr_type h, s, nx, ps, ph, ns, total;
      logic     p, n;
      h = {16'b0, off[15:3], 3'b000} - WORD_BYTES;
      s = tag_size_at(h);
      set_tag(h, s, 1'b0, prev_alloc(h));
      store_tag(h + s - WORD_BYTES, s);
      nx = h + s;
      set_tag(nx, tag_size_at(nx), is_alloc(nx), 1'b0);
      p = prev_alloc(h);
      n = is_alloc(nx);
      if (!p) begin
         // merge into the previous block, and the next one too when it is free
         ps = tag_size_at(h - WORD_BYTES);
         ph = h - ps;
         ns = n ? '0 : tag_size_at(nx);
         total = (ps + ns + s) & TAG_FIELD;
         set_tag(ph, total & SIZE_FIELD, 1'b0, prev_alloc(ph));
         store_tag(ph + (total & SIZE_FIELD) - WORD_BYTES, total);
      end else if (!n) begin
         total = (tag_size_at(nx) + s) & TAG_FIELD;
         set_tag(h, total & SIZE_FIELD, 1'b0, prev_alloc(h));
         store_tag(h + (total & SIZE_FIELD) - WORD_BYTES, total);
      end
   endfunction

   function automatic rsp_type predict_rsp(input req_type it);
      rsp_type     r;
      logic [15:0] grant;
      r = '0;
      r.status = STATUS_DONE;
      if (it.kind == KIND_FORMAT) begin
         format_heap();
      end else if (it.kind == KIND_UNKNOWN) begin
         r.status = STATUS_IGNORED;
      end else if (!model_formatted) begin
         r.status = STATUS_NOTFMT;
      end else if (it.kind == KIND_ALLOC) begin
         if (it.request_bytes == 0) begin
            r.status = STATUS_IGNORED;
         end else begin
            r.status = grant_block(it.request_bytes, grant);
            r.granted_offset = grant;
         end
      end else if (it.release_offset < 8) begin
         r.status = STATUS_IGNORED;
      end else begin
         release_block(it.release_offset);
      end
      return r;
   endfunction

   // an item that would read heap words never written is swapped for a format
   function automatic rsp_type plan_item(input req_type wanted, output req_type chosen);
      rsp_type r;
      heap_saved      = heap_model;
      written_saved   = heap_written;
      formatted_saved = model_formatted;
      blank_read      = 1'b0;
      chosen = wanted;
      r = predict_rsp(chosen);
      if (blank_read) begin
         heap_model      = heap_saved;
         heap_written    = written_saved;
         model_formatted = formatted_saved;
         chosen.kind     = KIND_FORMAT;
         r = predict_rsp(chosen);
      end
      return r;
   endfunction

   function automatic req_type make_item(input logic [1:0] kind, input logic [16:0] bytes,
                                         input logic [15:0] off);
      req_type it;
      it.kind           = kind;
      it.request_bytes  = bytes;
      it.release_offset = off;
      return it;
   endfunction

   // ---------------- driving ----------------

   task automatic send_item(input req_type wanted);
      req_type     it;
      rsp_type     r;
      int unsigned gap;
      r = plan_item(wanted, it);
      case (it.kind)
         KIND_FORMAT: live_offsets.delete();
         KIND_ALLOC: if (r.status == STATUS_DONE) live_offsets.push_back(r.granted_offset);
         KIND_FREE: if (r.status == STATUS_DONE) begin
            for (int i = live_offsets.size() - 1; i >= 0; i--)
               if (live_offsets[i][15:3] == it.release_offset[15:3]) live_offsets.delete(i);
         end
         default: ;
      endcase
      last_grant = r.granted_offset;
      req_item   <= it;
      start      <= 1'b1;
      start_high = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsps.push_back(r);
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap != 0) begin
         start      <= 1'b0;
         start_high = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      if (start_high) begin
         start      <= 1'b0;
         start_high = 1'b0;
      end
      while (expected_rsps.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_heap_length(input tag_type value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      model_heap_len = value;
      csr_we <= 1'b0;
   endtask

   // ---------------- tests ----------------

   task automatic test_before_format();
      sender_idle_pct = 0;
      send_item(make_item(KIND_ALLOC, 17'd16, '0));
      send_item(make_item(KIND_FREE, '0, 16'd16));
      send_item(make_item(KIND_UNKNOWN, 17'd5, 16'd24));
      settle();
   endtask

   task automatic test_ignored_items();
      write_heap_length(17'd65536);
      send_item(make_item(KIND_FORMAT, '0, '0));
      send_item(make_item(KIND_ALLOC, '0, 16'hFFFF));
      send_item(make_item(KIND_FREE, 17'h1FFFF, '0));
      send_item(make_item(KIND_FREE, '0, 16'd7));
      settle();
   endtask

   task automatic test_split_and_merge();
      logic [15:0] grant_a, grant_b, grant_c;
      send_item(make_item(KIND_ALLOC, 17'd1, '0));
      grant_a = last_grant;
      send_item(make_item(KIND_ALLOC, 17'd24, '0));
      grant_b = last_grant;
      send_item(make_item(KIND_ALLOC, 17'd1000, '0));
      grant_c = last_grant;
      send_item(make_item(KIND_ALLOC, 17'd65536, '0));
      // middle block has allocated neighbours, then both-sided and next-only merges
      send_item(make_item(KIND_FREE, '0, grant_b));
      send_item(make_item(KIND_FREE, '0, grant_c));
      send_item(make_item(KIND_FREE, '0, grant_a));
      // exact fit of the whole heap, no split
      send_item(make_item(KIND_ALLOC, 17'd65512, '0));
      grant_a = last_grant;
      send_item(make_item(KIND_ALLOC, 17'd1, '0));
      send_item(make_item(KIND_FREE, '0, grant_a));
      settle();
   endtask

   task automatic test_bad_release();
      sender_idle_pct = 57;
      send_item(make_item(KIND_FREE, '0, 16'd19));
      send_item(make_item(KIND_FREE, '0, 16'hFFFF));
      send_item(make_item(KIND_FREE, '0, 16'h8001));
      settle();
   endtask

   task automatic test_minimum_heap();
      sender_idle_pct = 30;
      write_heap_length(17'd32);
      send_item(make_item(KIND_FORMAT, '0, '0));
      send_item(make_item(KIND_ALLOC, 17'd8, '0));
      send_item(make_item(KIND_ALLOC, 17'd1, '0));
      send_item(make_item(KIND_FREE, '0, 16'd16));
      send_item(make_item(KIND_ALLOC, 17'd9, '0));
      settle();
   endtask

   task automatic run_random_phase(input tag_type length, input int unsigned idle_pct,
                                   input int unsigned count);
      req_type     it;
      int unsigned roll;
      int unsigned k;
      sender_idle_pct = idle_pct;
      write_heap_length(length);
      send_item(make_item(KIND_FORMAT, '0, '0));
      for (k = 0; k < count; k++) begin
         it.request_bytes  = 17'($urandom_range(65536));
         it.release_offset = 16'($urandom);
         roll = $urandom_range(99);
         if (roll < 2) begin
            it.kind = KIND_FORMAT;
         end else if (roll < 4) begin
            it.kind = KIND_UNKNOWN;
         end else if (roll < (live_offsets.size() > 24 ? 40 : 55)) begin
            it.kind = KIND_ALLOC;
            roll = $urandom_range(99);
            if (roll < 4) it.request_bytes = '0;
            else if (roll < 60) it.request_bytes = 17'($urandom_range(64, 1));
            else if (roll < 90) it.request_bytes = 17'($urandom_range(1024, 1));
         end else begin
            it.kind = KIND_FREE;
            roll = $urandom_range(99);
            if (roll < 80 && live_offsets.size() != 0) begin
               it.release_offset = live_offsets[$urandom_range(live_offsets.size() - 1)];
               // low offset bits are dropped by the block, same header
               if (roll < 8) it.release_offset[2:0] = 3'($urandom_range(7));
            end else if (roll < 88) begin
               it.release_offset = 16'($urandom_range(7));
            end
         end
         send_item(it);
      end
      settle();
   endtask

   // ---------------- result checking ----------------

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual offset %0d status %0d",
                     $time, rsp_item.granted_offset, rsp_item.status);
            mismatches++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_item.granted_offset !== want.granted_offset) begin
               $display("%0t: granted_offset expected %0d actual %0d",
                        $time, want.granted_offset, rsp_item.granted_offset);
               mismatches++;
            end
            if (rsp_item.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_item.status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stalled_cycles <= 0;
      else stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned w;
      for (w = 0; w < HEAP_WORDS; w++) begin
         heap_model[w]   = '0;
         heap_written[w] = 1'b0;
      end
      model_heap_len  = HEAP_LEN_RESET;
      model_formatted = 1'b0;
      start_high      = 1'b0;
      sender_idle_pct = 0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_item  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= HEAP_LEN_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_before_format();
      test_ignored_items();
      test_split_and_merge();
      test_bad_release();
      test_minimum_heap();
      run_random_phase(17'd65536, 0, 160);
      run_random_phase(17'd32, 57, 60);
      run_random_phase(17'd1000, 30, 160);
      run_random_phase(17'd65535, 57, 160);
      run_random_phase(17'd256, 0, 160);
      run_random_phase(17'd4096, 30, 160);
      run_random_phase(17'd48, 57, 80);
      run_random_phase(17'd20000, 0, 160);
      run_random_phase(17'd65536, 30, 160);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
